@@ hdl/launch_vehicle_sequence_model_top_defines.svh @@
// ----------------------------------------------------------------------------
// Launch vehicle sequence model - assertion macros
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LAUNCH_VEHICLE_SEQUENCE_MODEL_TOP_DEFINES_SVH
`define LAUNCH_VEHICLE_SEQUENCE_MODEL_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check a property at every clock edge out of reset
`define LVSM_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// check that a condition implies another in the next cycle
`define LVSM_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define LVSM_ASSERT(name, prop, msg)
`define LVSM_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

@@ hdl/lvsm_pkg.sv @@
// ----------------------------------------------------------------------------
// Launch vehicle sequence model - package
// Widths, register indexes, event codes, reset values and timer helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package lvsm_pkg;

	// timer width and the width used to compare a timer with a 32-bit delay
	localparam int unsigned TIMER_WIDTH = 32;
	localparam int unsigned CFG_WIDTH   = 32;
	localparam int unsigned CMP_WIDTH   = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
	localparam int unsigned DT_WIDTH    = 16;

	typedef logic [TIMER_WIDTH-1:0] tmr_t;
	typedef logic [CFG_WIDTH-1:0]   cfg_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_START_DELAY   = 2'd0,
		CFG_LIFTOFF_DELAY = 2'd1,
		CFG_ASCENT_DUR    = 2'd2,
		CFG_STOP_DELAY    = 2'd3
	} cfg_idx_t;

	// injected event codes; unused codes act as none
	typedef enum logic [2:0] {
		EV_NONE          = 3'd0,
		EV_INHIBIT_START = 3'd1,
		EV_INHIBIT_STOP  = 3'd2,
		EV_INHIBIT_LIFT  = 3'd3,
		EV_FORCE_STOP    = 3'd4,
		EV_FORCE_RESTART = 3'd5
	} event_t;

	// timer slots
	typedef enum logic [1:0] {
		T_START = 2'd0,
		T_LIFT  = 2'd1,
		T_ASC   = 2'd2,
		T_STOP  = 2'd3
	} tmr_idx_t;

	localparam cfg_t START_DELAY_RST   = cfg_t'(3000000);
	localparam cfg_t LIFTOFF_DELAY_RST = cfg_t'(2000000);
	localparam cfg_t ASCENT_DUR_RST    = cfg_t'(60000000);
	localparam cfg_t STOP_DELAY_RST    = cfg_t'(1000000);

	// advance a timer by one interval, saturating at all ones
	function automatic tmr_t tmr_advance(input tmr_t t, input logic [DT_WIDTH-1:0] dt);
		logic [TIMER_WIDTH:0] sum;
		sum = {1'b0, t} + (TIMER_WIDTH+1)'(dt);
		return sum[TIMER_WIDTH] ? {TIMER_WIDTH{1'b1}} : sum[TIMER_WIDTH-1:0];
	endfunction

	// timer reached its delay
	function automatic logic tmr_reached(input tmr_t t, input cfg_t lim);
		return CMP_WIDTH'(t) >= CMP_WIDTH'(lim);
	endfunction

endpackage

`default_nettype wire

@@ hdl/launch_vehicle_sequence_model_top.sv @@
// Pipeline: an accepted item is loaded into the input register, then into the
// flag/result register when that register is free or being taken.
// Throughput: one item per clock while the result is not stalled; the combinational
// timer update loop (four saturating adders and delay compares) sets this figure.
// Reset: arst_n clears timers, inhibits, flags and handshake state at once and
// reloads the four delay registers with their defaults.
// ----------------------------------------------------------------------------
// Launch vehicle sequence model - top level
// Runs engine start, liftoff, ascent and stop timers one interval per item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "launch_vehicle_sequence_model_top_defines.svh"

module launch_vehicle_sequence_model_top
	import lvsm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration write port
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [CFG_WIDTH-1:0] cfg_data,
	// input channel
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                ignition_command,
	input  wire logic [DT_WIDTH-1:0] delta_time,
	input  wire logic [2:0]          injected_event,
	// result channel
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     engine_running,
	output logic                     liftoff_detected,
	output logic                     cutoff_condition_met
);

	// configuration registers
	cfg_t start_delay_q, liftoff_delay_q, ascent_dur_q, stop_delay_q;

	// input stage
	logic                valid_s1;
	logic                ign_s1;
	logic [DT_WIDTH-1:0] dt_s1;
	logic [2:0]          ev_s1;

	// sequence state
	tmr_t       tmr_q [4];
	logic [3:0] active_q;
	logic [2:0] inh_q;
	logic       run_q, lift_q, cut_q;
	logic       last_ign_q;
	logic       out_valid_q;

	// next state
	tmr_t       tmr_d [4];
	logic [3:0] active_d;
	logic [2:0] inh_d;
	logic       run_d, lift_d, cut_d;

	logic advance;
	logic in_fire;

	// the stage advances when it holds an item and the result register is free or being taken
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	// write delay registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delay_q   <= START_DELAY_RST;
			liftoff_delay_q <= LIFTOFF_DELAY_RST;
			ascent_dur_q    <= ASCENT_DUR_RST;
			stop_delay_q    <= STOP_DELAY_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_START_DELAY:   start_delay_q   <= cfg_data;
				CFG_LIFTOFF_DELAY: liftoff_delay_q <= cfg_data;
				CFG_ASCENT_DUR:    ascent_dur_q    <= cfg_data;
				CFG_STOP_DELAY:    stop_delay_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture the input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ign_s1 <= ignition_command;
			dt_s1  <= delta_time;
			ev_s1  <= injected_event;
		end
	end

	// one interval: event, ignition edges, advance, expiries
	always_comb begin
		tmr_t       t [4];
		logic [3:0] act;
		logic [2:0] inh;
		logic       run;
		logic       x_start, x_lift, x_asc, x_stop;

		t   = tmr_q;
		act = active_q;
		inh = inh_q;
		run = run_q;

		// apply the injected event
		case (ev_s1)
			EV_INHIBIT_START: inh[0] = 1'b1;
			EV_INHIBIT_STOP:  inh[1] = 1'b1;
			EV_INHIBIT_LIFT:  inh[2] = 1'b1;
			EV_FORCE_STOP: begin
				run = 1'b0;
				act[T_STOP]  = 1'b0;
				t[T_STOP]    = '0;
				act[T_START] = 1'b0;
				t[T_START]   = '0;
			end
			EV_FORCE_RESTART: begin
				run = 1'b1;
				act[T_STOP] = 1'b0;
				t[T_STOP]   = '0;
			end
			default: ;
		endcase

		// ignition rising edge starts the start timer, falling edge the stop timer if the engine runs
		if (!last_ign_q && ign_s1) begin
			act[T_START] = 1'b1;
			t[T_START]   = '0;
			act[T_STOP]  = 1'b0;
			t[T_STOP]    = '0;
		end
		if (last_ign_q && !ign_s1) begin
			act[T_START] = 1'b0;
			t[T_START]   = '0;
			if (run) begin
				act[T_STOP] = 1'b1;
				t[T_STOP]   = '0;
			end
		end

		// advance the active timers
		for (int i = 0; i < 4; i++) begin
			if (act[i]) begin
				t[i] = tmr_advance(t[i], dt_s1);
			end
		end

		// capture expiries before any transition
		x_start = act[T_START] && tmr_reached(t[T_START], start_delay_q);
		x_lift  = act[T_LIFT]  && tmr_reached(t[T_LIFT],  liftoff_delay_q);
		x_asc   = act[T_ASC]   && tmr_reached(t[T_ASC],   ascent_dur_q);
		x_stop  = act[T_STOP]  && tmr_reached(t[T_STOP],  stop_delay_q);

		lift_d = lift_q;
		cut_d  = cut_q;

		if (x_start) begin
			act[T_START] = 1'b0;
			t[T_START]   = '0;
			if (!inh[0]) begin
				run = 1'b1;
				act[T_LIFT] = 1'b1;
				t[T_LIFT]   = '0;
			end
		end
		if (x_lift) begin
			act[T_LIFT] = 1'b0;
			t[T_LIFT]   = '0;
			if (!inh[2]) begin
				lift_d = 1'b1;
				act[T_ASC] = 1'b1;
				t[T_ASC]   = '0;
			end
		end
		if (x_asc) begin
			act[T_ASC] = 1'b0;
			t[T_ASC]   = '0;
			cut_d = 1'b1;
		end
		if (x_stop) begin
			act[T_STOP] = 1'b0;
			t[T_STOP]   = '0;
			if (!inh[1]) begin
				run = 1'b0;
			end
		end

		tmr_d    = t;
		active_d = act;
		inh_d    = inh;
		run_d    = run;
	end

	// commit the interval; the flags double as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				tmr_q[i] <= '0;
			end
			active_q   <= '0;
			inh_q      <= '0;
			run_q      <= 1'b0;
			lift_q     <= 1'b0;
			cut_q      <= 1'b0;
			last_ign_q <= 1'b0;
		end else if (advance) begin
			tmr_q      <= tmr_d;
			active_q   <= active_d;
			inh_q      <= inh_d;
			run_q      <= run_d;
			lift_q     <= lift_d;
			cut_q      <= cut_d;
			last_ign_q <= ign_s1;
		end
	end

	// hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid            = out_valid_q;
	assign engine_running       = run_q;
	assign liftoff_detected     = lift_q;
	assign cutoff_condition_met = cut_q;

	// checks
	`LVSM_ASSERT_NEXT(a_lift_sticky, lift_q, lift_q, "liftoff flag dropped")
	`LVSM_ASSERT_NEXT(a_cut_sticky, cut_q, cut_q, "cutoff flag dropped")
	`LVSM_ASSERT(a_cut_after_lift, !cut_q || lift_q, "cutoff without liftoff")
	`LVSM_ASSERT_NEXT(a_stall_holds_s1, valid_s1 && out_valid_q && !out_ready,
		valid_s1 && $stable(run_q) && $stable(active_q), "stage advanced into a stalled result")
	`LVSM_ASSERT_NEXT(a_fire_fills_s1, in_fire, valid_s1, "accepted item lost")

endmodule

`default_nettype wire
